// ----- hdl/pcsm_pkg.sv -----
// Shared types and constants for the paged cache slot mapper.
package pcsm_pkg;

    localparam int BLK_LEN_W    = 11;
    localparam int PAD_W        = 32;
    localparam int ENTRY_W      = 32;
    localparam int SLOT_W       = 42;
    localparam int REQ_W        = 8;
    localparam int COL_W        = 8;
    localparam int POS_PORT_W   = 20;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 32;

    localparam int MAX_REQUESTS_DEF           = 256;
    localparam int MAX_BLOCKS_PER_REQUEST_DEF = 256;
    localparam int POSITION_BITS_DEF          = 20;

    localparam logic [BLK_LEN_W-1:0] BLK_LEN_RESET   = BLK_LEN_W'(16);
    localparam logic [PAD_W-1:0]     PAD_VALUE_RESET = '1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_MAP   = 2'd1,
        ACT_PAD   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLK_LEN   = CFG_INDEX_W'(0),
        REG_PAD_VALUE = CFG_INDEX_W'(1)
    } cfg_reg_t;

    typedef struct packed {
        action_t            action;
        logic [REQ_W-1:0]   request;
        logic [COL_W-1:0]   column;
        logic [ENTRY_W-1:0] entry;
    } item_t;

    typedef struct packed {
        action_t              action;
        logic                 out_of_range;
        logic [BLK_LEN_W-1:0] rem;
    } lookup_t;

endpackage

// ----- hdl/pcsm_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, items travel alongside.
module pcsm_div #(
    parameter int POSITION_BITS = pcsm_pkg::POSITION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pcsm_pkg::item_t                      in_item,
    input  logic [POSITION_BITS-1:0]             dividend,
    input  logic [pcsm_pkg::BLK_LEN_W-1:0]       blk_len,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pcsm_pkg::item_t                      out_item,
    output logic [POSITION_BITS-1:0]             quotient,
    output logic [pcsm_pkg::BLK_LEN_W-1:0]       remainder
);
    import pcsm_pkg::*;

    logic                     v_reg    [POSITION_BITS];
    item_t                    item_reg [POSITION_BITS];
    logic [BLK_LEN_W-1:0]     rem_reg  [POSITION_BITS];
    logic [POSITION_BITS-1:0] work_reg [POSITION_BITS];
    logic                     stall_s  [POSITION_BITS];

    for (genvar j = 0; j < POSITION_BITS; j++)
    begin : g_step
        logic                     v_in;
        item_t                    item_in;
        logic [BLK_LEN_W-1:0]     rem_in;
        logic [POSITION_BITS-1:0] work_in;
        logic                     stall_nx;
        logic [BLK_LEN_W:0]       trial;
        logic [BLK_LEN_W:0]       diff;
        logic                     qbit;
        logic [BLK_LEN_W-1:0]     rem_next;
        logic [POSITION_BITS-1:0] work_next;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_item;
            assign rem_in  = '0;
            assign work_in = dividend;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[j-1];
            assign item_in = item_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign work_in = work_reg[j-1];
        end

        if (j == POSITION_BITS - 1)
        begin : g_last
            assign stall_nx = out_stall;
        end
        else
        begin : g_inner
            assign stall_nx = stall_s[j+1];
        end

        assign stall_s[j] = v_reg[j] & stall_nx;

        assign trial     = {rem_in, work_in[POSITION_BITS-1]};
        assign diff      = trial - {1'b0, blk_len};
        assign qbit      = (trial >= {1'b0, blk_len});
        assign rem_next  = qbit ? diff[BLK_LEN_W-1:0] : trial[BLK_LEN_W-1:0];
        assign work_next = {work_in[POSITION_BITS-2:0], qbit};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (!stall_s[j])
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!stall_s[j])
            begin
                item_reg[j] <= item_in;
                rem_reg[j]  <= rem_next;
                work_reg[j] <= work_next;
            end
        end
    end

    assign in_stall  = stall_s[0];
    assign out_valid = v_reg[POSITION_BITS-1];
    assign out_item  = item_reg[POSITION_BITS-1];
    assign quotient  = work_reg[POSITION_BITS-1];
    assign remainder = rem_reg[POSITION_BITS-1];

endmodule

// ----- hdl/pcsm_table.sv -----
// Block table: address and range check stage, then memory write or registered read.
module pcsm_table #(
    parameter int POSITION_BITS          = pcsm_pkg::POSITION_BITS_DEF,
    parameter int MAX_REQUESTS           = pcsm_pkg::MAX_REQUESTS_DEF,
    parameter int MAX_BLOCKS_PER_REQUEST = pcsm_pkg::MAX_BLOCKS_PER_REQUEST_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pcsm_pkg::item_t                      in_item,
    input  logic [POSITION_BITS-1:0]             quotient,
    input  logic [pcsm_pkg::BLK_LEN_W-1:0]       remainder,
    input  logic [pcsm_pkg::BLK_LEN_W-1:0]       blk_len,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pcsm_pkg::lookup_t                    out_lookup,
    output logic [pcsm_pkg::ENTRY_W-1:0]         out_entry
);
    import pcsm_pkg::*;

    localparam int TABLE_DEPTH = MAX_REQUESTS * MAX_BLOCKS_PER_REQUEST;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic               v_a_reg;
    lookup_t            look_a_reg;
    logic [ADDR_W-1:0]  addr_a_reg;
    logic               wr_a_reg;
    logic [ENTRY_W-1:0] entry_a_reg;

    logic               v_m_reg;
    lookup_t            look_m_reg;
    logic [ENTRY_W-1:0] rd_reg;

    logic               stall_a;
    logic               stall_m;

    logic               req_bad;
    logic               col_bad;
    logic               bidx_bad;
    logic [31:0]        idx;
    logic [31:0]        addr_full;
    lookup_t            look_next;
    logic               wr_next;

    assign stall_m  = v_m_reg & out_stall;
    assign stall_a  = v_a_reg & stall_m;
    assign in_stall = stall_a;

    always_comb
    begin
        req_bad   = 32'(in_item.request) >= 32'(MAX_REQUESTS);
        col_bad   = 32'(in_item.column) >= 32'(MAX_BLOCKS_PER_REQUEST);
        bidx_bad  = 32'(quotient) >= 32'(MAX_BLOCKS_PER_REQUEST);
        idx       = (in_item.action == ACT_WRITE) ? 32'(in_item.column) : 32'(quotient);
        addr_full = 32'(in_item.request) * 32'(MAX_BLOCKS_PER_REQUEST) + idx;
        wr_next   = (in_item.action == ACT_WRITE) & !req_bad & !col_bad;
        look_next.action       = in_item.action;
        look_next.out_of_range = req_bad | bidx_bad | (blk_len == '0);
        look_next.rem          = remainder;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_m_reg <= 1'b0;
        end
        else
        begin
            if (!stall_a)
            begin
                v_a_reg <= in_valid;
            end
            if (!stall_m)
            begin
                v_m_reg <= v_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_a)
        begin
            look_a_reg  <= look_next;
            addr_a_reg  <= addr_full[ADDR_W-1:0];
            wr_a_reg    <= wr_next;
            entry_a_reg <= in_item.entry;
        end
        if (!stall_m)
        begin
            look_m_reg <= look_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_m)
        begin
            if (v_a_reg && wr_a_reg)
            begin
                mem[addr_a_reg] <= entry_a_reg;
            end
            rd_reg <= mem[addr_a_reg];
        end
    end

    assign out_valid  = v_m_reg;
    assign out_lookup = look_m_reg;
    assign out_entry  = rd_reg;

endmodule

// ----- hdl/pcsm_slot.sv -----
// Slot arithmetic: block times block length, then offset add and result register.
module pcsm_slot (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pcsm_pkg::lookup_t                    in_lookup,
    input  logic [pcsm_pkg::ENTRY_W-1:0]         in_entry,
    input  logic [pcsm_pkg::BLK_LEN_W-1:0]       blk_len,
    input  logic [pcsm_pkg::PAD_W-1:0]           pad_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pcsm_pkg::SLOT_W-1:0]          slot,
    output logic                                 out_of_range
);
    import pcsm_pkg::*;

    logic signed [ENTRY_W+BLK_LEN_W:0] prod_full;
    logic [SLOT_W-1:0] pad_ext;

    logic              v_p_reg;
    lookup_t           look_p_reg;
    logic [SLOT_W-1:0] prod_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              oor_reg;

    logic              stall_o;
    logic              stall_p;
    logic              emit_next;
    logic [SLOT_W-1:0] slot_next;
    logic              oor_next;

    assign stall_o  = out_valid_reg & out_stall;
    assign stall_p  = v_p_reg & stall_o;
    assign in_stall = stall_p;

    assign prod_full = $signed(in_entry) * $signed({1'b0, blk_len});
    assign pad_ext   = SLOT_W'($signed(pad_value));

    always_comb
    begin
        emit_next = (look_p_reg.action == ACT_MAP) || (look_p_reg.action == ACT_PAD);
        slot_next = pad_ext;
        oor_next  = 1'b0;
        case (look_p_reg.action)
            ACT_MAP:
            begin
                if (look_p_reg.out_of_range)
                begin
                    oor_next = 1'b1;
                end
                else
                begin
                    slot_next = prod_reg + SLOT_W'(look_p_reg.rem);
                end
            end
            default:
            begin
                slot_next = pad_ext;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_p_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall_p)
            begin
                v_p_reg <= in_valid;
            end
            if (!stall_o)
            begin
                out_valid_reg <= v_p_reg & emit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_p)
        begin
            look_p_reg <= in_lookup;
            prod_reg   <= prod_full[SLOT_W-1:0];
        end
        if (!stall_o)
        begin
            slot_reg <= slot_next;
            oor_reg  <= oor_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = slot_reg;
    assign out_of_range = oor_reg;

endmodule

// ----- hdl/paged_cache_slot_mapper_unit.sv -----
// Paged cache slot mapper top level: configuration registers and stage chain.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  input    | in_valid / in_stall   | action, request, table_column, entry_value, position
//  result   | out_valid / out_stall | slot, out_of_range
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; the divider gives one quotient bit per stage.
//  Write items update the table in order with lookups and give no transfer on the result side.
//  out_stall holds only the stages that are full; bubbles close up behind a held result.
//  Reset clears valid bits and sets the block length to 16 and pad_value to -1; table is not
//  cleared.
module paged_cache_slot_mapper_unit #(
    parameter int MAX_REQUESTS           = pcsm_pkg::MAX_REQUESTS_DEF,
    parameter int MAX_BLOCKS_PER_REQUEST = pcsm_pkg::MAX_BLOCKS_PER_REQUEST_DEF,
    parameter int POSITION_BITS          = pcsm_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [pcsm_pkg::REQ_W-1:0]          request,
    input  logic [pcsm_pkg::COL_W-1:0]          table_column,
    input  logic signed [pcsm_pkg::ENTRY_W-1:0] entry_value,
    input  logic [pcsm_pkg::POS_PORT_W-1:0]     position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pcsm_pkg::SLOT_W-1:0]  slot,
    output logic                                out_of_range,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pcsm_pkg::*;

    logic [BLK_LEN_W-1:0]    blk_len_reg;
    logic [PAD_W-1:0]        pad_value_reg;

    item_t                    in_item;
    logic [POSITION_BITS-1:0] dividend;

    logic                     div_valid;
    logic                     div_stall;
    item_t                    div_item;
    logic [POSITION_BITS-1:0] div_quot;
    logic [BLK_LEN_W-1:0]     div_rem;

    logic                     tab_valid;
    logic                     tab_stall;
    lookup_t                  tab_lookup;
    logic [ENTRY_W-1:0]       tab_entry;

    logic [SLOT_W-1:0]        slot_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_len_reg   <= BLK_LEN_RESET;
            pad_value_reg <= PAD_VALUE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLK_LEN:   blk_len_reg   <= cfg_data[BLK_LEN_W-1:0];
                REG_PAD_VALUE: pad_value_reg <= cfg_data[PAD_W-1:0];
                default:       ;
            endcase
        end
    end

    assign in_item.action  = action_t'(action);
    assign in_item.request = request;
    assign in_item.column  = table_column;
    assign in_item.entry   = entry_value;
    assign dividend        = POSITION_BITS'(position);

    pcsm_div #(
        .POSITION_BITS(POSITION_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .dividend   (dividend),
        .blk_len    (blk_len_reg),
        .out_valid  (div_valid),
        .out_stall  (div_stall),
        .out_item   (div_item),
        .quotient   (div_quot),
        .remainder  (div_rem)
    );

    pcsm_table #(
        .POSITION_BITS          (POSITION_BITS),
        .MAX_REQUESTS           (MAX_REQUESTS),
        .MAX_BLOCKS_PER_REQUEST (MAX_BLOCKS_PER_REQUEST)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_stall   (div_stall),
        .in_item    (div_item),
        .quotient   (div_quot),
        .remainder  (div_rem),
        .blk_len    (blk_len_reg),
        .out_valid  (tab_valid),
        .out_stall  (tab_stall),
        .out_lookup (tab_lookup),
        .out_entry  (tab_entry)
    );

    pcsm_slot u_slot (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (tab_valid),
        .in_stall     (tab_stall),
        .in_lookup    (tab_lookup),
        .in_entry     (tab_entry),
        .blk_len      (blk_len_reg),
        .pad_value    (pad_value_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot_bits),
        .out_of_range (out_of_range)
    );

    assign slot = $signed(slot_bits);

endmodule
